[rtl/dq_pkg.sv]
// Shared types and constants for the double-ended queue.
package dq_pkg;

  // Action codes carried on the action port. Codes above ACT_QUERY act as a query.
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_QUERY      = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH,
    ST_SHOW
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture a new word from the input ports
    logic exec;   // apply the action to the ring and read the popped slot
    logic fetch;  // capture the popped value and read the new front and back
    logic show;   // result is on the output ports
  } cmd_t;

endpackage

[rtl/double_ended_queue.sv]
// Top level of the double-ended queue: controller plus ring buffer datapath.
//
// The block keeps a double-ended queue of signed 32-bit values in a ring
// buffer of DEPTH entries. A word is accepted at a rising clock edge where
// start is high and busy is low; action selects push front, push back, pop
// front, pop back or query, and value carries the data for a push.
// Every accepted word gives exactly one result word, shown on the result
// ports for one cycle while done is high. The receiver cannot stall, so the
// result must be taken in that cycle.
// A new word is not accepted until the last one is through: after the
// accepting cycle the ring is updated and the popped slot is read, then
// the new front and back slots are read, and then the result is shown.
// The result is on the ports in the show state and is taken at its end.
// This sequence is set by the registered read of the slot memory, which
// is needed once for the popped value and again for the new ends.
// A push on a full queue is dropped and flagged by overflow; a pop on an
// empty queue leaves the queue as it is with pop_done low.
// Reset empties the queue at once by clearing the head pointer and the fill
// count; the slot memory itself is not cleared and needs no sweep.
module double_ended_queue #(
  parameter int DEPTH = 1024,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action,
  input  logic signed [31:0] value,
  output logic               done,
  output logic signed [31:0] popped_value,
  output logic               pop_done,
  output logic               overflow,
  output logic [CW-1:0]      count_now,
  output logic               empty_now,
  output logic signed [31:0] front_value,
  output logic signed [31:0] back_value
);
  import dq_pkg::*;

  cmd_t cmd;

  // The controller sequences each word through execute, fetch and show.
  dq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // The datapath holds the ring, its pointers and the result registers.
  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .action       (action),
    .value        (value),
    .popped_value (popped_value),
    .pop_done     (pop_done),
    .overflow     (overflow),
    .count_now    (count_now),
    .empty_now    (empty_now),
    .front_value  (front_value),
    .back_value   (back_value)
  );

  // The result ports are valid only in the show cycle.
  assign done = cmd.show;

endmodule

[rtl/dq_ctrl.sv]
// Sequencing state machine for the double-ended queue.
module dq_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  output dq_pkg::cmd_t cmd
);
  import dq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC:  state_next = ST_FETCH;
      ST_FETCH: state_next = ST_SHOW;
      ST_SHOW:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_EXEC:  cmd.exec  = 1'b1;
      ST_FETCH: cmd.fetch = 1'b1;
      ST_SHOW:  cmd.show  = 1'b1;
      default:  busy      = 1'b1;
    endcase
  end

endmodule

[rtl/dq_datapath.sv]
// Ring buffer storage, head pointer, fill count and result registers.
module dq_datapath #(
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  dq_pkg::cmd_t       cmd,
  input  logic [2:0]         action,
  input  logic signed [31:0] value,
  output logic signed [31:0] popped_value,
  output logic               pop_done,
  output logic               overflow,
  output logic [CW-1:0]      count_now,
  output logic               empty_now,
  output logic signed [31:0] front_value,
  output logic signed [31:0] back_value
);
  import dq_pkg::*;

  logic [31:0]   mem [DEPTH];
  logic [2:0]    act;
  logic [31:0]   val;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [31:0]   rdata_a;
  logic [31:0]   rdata_b;
  logic [31:0]   popped;
  logic          popped_flag;
  logic          ovf;

  logic          is_push;
  logic          is_pop;
  logic          full;
  logic          empty;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] back_addr;
  logic [AW-1:0] tail_addr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr_a;

  // Offset from the head, folded back into the ring with one compare and subtract.
  function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign is_push   = (act == ACT_PUSH_FRONT) || (act == ACT_PUSH_BACK);
  assign is_pop    = (act == ACT_POP_FRONT) || (act == ACT_POP_BACK);
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign head_dec  = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign head_inc  = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
  assign back_addr = ring_at(head, count - CW'(1));
  assign tail_addr = ring_at(head, count);

  assign we      = cmd.exec && is_push && !full;
  assign waddr   = (act == ACT_PUSH_FRONT) ? head_dec : tail_addr;
  assign raddr_a = (cmd.exec && (act == ACT_POP_BACK)) ? back_addr : head;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= val;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[back_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action;
      val <= value;
    end
    if (cmd.exec) begin
      popped_flag <= is_pop && !empty;
      ovf         <= is_push && full;
    end
    if (cmd.fetch) begin
      popped <= popped_flag ? rdata_a : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      if (is_push && !full) begin
        count <= count + CW'(1);
        if (act == ACT_PUSH_FRONT) begin
          head <= head_dec;
        end
      end else if (is_pop && !empty) begin
        count <= count - CW'(1);
        if (act == ACT_POP_FRONT) begin
          head <= head_inc;
        end
      end
    end
  end

  assign popped_value = popped;
  assign pop_done     = popped_flag;
  assign overflow     = ovf;
  assign count_now    = count;
  assign empty_now    = empty;
  assign front_value  = empty ? '0 : rdata_a;
  assign back_value   = empty ? '0 : rdata_b;

endmodule
